// ===== rtl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types, codes and constants of the deadline-ordered job scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

  // Sizes
  localparam int NUM_TYPES         = 3;
  localparam int TABLE_DEPTH_DEF   = 4;
  localparam int TYPE_W            = 2;
  localparam int REM_W             = 16;
  localparam int TIME_W            = 32;
  localparam int SERIAL_W          = 32;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SERVICE0  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVICE1  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVICE2  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADLINE0 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADLINE1 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADLINE2 = 3'd5;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] SERVICE0_RST  = 16'd500;
  localparam logic [CFG_DATA_W-1:0] SERVICE1_RST  = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SERVICE2_RST  = 16'd200;
  localparam logic [CFG_DATA_W-1:0] DEADLINE0_RST = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] DEADLINE1_RST = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] DEADLINE2_RST = 16'd300;

  // Job type codes
  localparam logic [TYPE_W-1:0] JOB_TYPE0 = 2'd0;
  localparam logic [TYPE_W-1:0] JOB_TYPE1 = 2'd1;
  localparam logic [TYPE_W-1:0] JOB_TYPE2 = 2'd2;

  // Input kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_ARRIVE = 1'b1;

  // Event codes
  localparam logic [1:0] EV_RECEIVE = 2'd0;
  localparam logic [1:0] EV_FINISH  = 2'd1;
  localparam logic [1:0] EV_DROP    = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [TYPE_W-1:0] job_type;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          event_res;
    logic [TYPE_W-1:0]   event_type;
    logic [SERIAL_W-1:0] serial_number;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEND_RECV,
    ST_FIN,
    ST_SEND_LAST
  } edf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic tick;
    logic insert;
    logic decrement;
    logic load_recv;
    logic load_fin;
    logic load_drop;
  } edf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic arrival;
    logic type_bad;
    logic full;
    logic empty;
    logic announced;
    logic head_done;
    logic out_last;
  } edf_status_t;

endpackage

// ===== rtl/edf_ctrl.sv =====
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer: takes one input beat, decides the table operation and walks the
// result beats out one at a time.
// ----------------------------------------------------------------------------
module edf_ctrl
  import edf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  edf_status_t status,
  output edf_cmd_t    cmd
);

  edf_state_t state;
  edf_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.arrival) begin
          if (status.type_bad)  state_next = ST_IDLE;
          else if (status.full) state_next = ST_SEND_LAST;
          else                  state_next = ST_IDLE;
        end else if (status.empty) begin
          state_next = ST_IDLE;
        end else if (!status.announced) begin
          state_next = ST_SEND_RECV;
        end else if (status.head_done) begin
          state_next = ST_SEND_LAST;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEND_RECV: begin
        if (out_ready) state_next = status.out_last ? ST_IDLE : ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_SEND_LAST;
      end
      ST_SEND_LAST: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        if (status.arrival) begin
          if (!status.type_bad) begin
            if (status.full) cmd.load_drop = 1'b1;
            else             cmd.insert    = 1'b1;
          end
        end else begin
          cmd.tick = 1'b1;
          if (!status.empty) begin
            if (!status.announced) begin
              cmd.load_recv = 1'b1;
              cmd.decrement = !status.head_done;
            end else if (status.head_done) begin
              cmd.load_fin = 1'b1;
            end else begin
              cmd.decrement = 1'b1;
            end
          end
        end
      end
      ST_SEND_RECV: begin
        out_valid = 1'b1;
      end
      ST_FIN: begin
        cmd.load_fin = 1'b1;
      end
      ST_SEND_LAST: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/edf_dpath.sv =====
// ----------------------------------------------------------------------------
// edf_dpath
// Job table kept sorted by deadline as a row of cells, time base, per-type
// counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module edf_dpath
  import edf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  in_item_t               in_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  edf_cmd_t               cmd,
  output edf_status_t            status,
  output out_item_t              out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Configuration
  logic [CFG_DATA_W-1:0] service_time    [NUM_TYPES];
  logic [CFG_DATA_W-1:0] deadline_offset [NUM_TYPES];

  // Job table, no reset: only entries below held are ever read
  logic [TYPE_W-1:0] slot_type      [TABLE_DEPTH];
  logic [REM_W-1:0]  slot_remaining [TABLE_DEPTH];
  logic [TIME_W-1:0] slot_deadline  [TABLE_DEPTH];
  logic              slot_announced [TABLE_DEPTH];

  logic [CNT_W-1:0]    held;
  logic [TIME_W-1:0]   current_time;
  logic [SERIAL_W-1:0] receive_count [NUM_TYPES];
  logic [SERIAL_W-1:0] finish_count  [NUM_TYPES];

  // Captured input beat
  logic              cur_kind;
  logic [TYPE_W-1:0] cur_type;

  out_item_t out_reg;

  logic [CFG_DATA_W-1:0] sel_offset;
  logic [CFG_DATA_W-1:0] sel_service;
  logic [TIME_W-1:0]     new_deadline;
  logic [TYPE_W-1:0]     head_type;
  logic                  head_done;
  logic [SERIAL_W-1:0]   recv_inc;
  logic [SERIAL_W-1:0]   fin_inc;

  // Neighbor views of each cell
  logic                  gt      [TABLE_DEPTH];
  logic                  prev_gt [TABLE_DEPTH];
  logic [TYPE_W-1:0]     up_type [TABLE_DEPTH];
  logic [REM_W-1:0]      up_rem  [TABLE_DEPTH];
  logic [TIME_W-1:0]     up_dl   [TABLE_DEPTH];
  logic                  up_ann  [TABLE_DEPTH];
  logic [TYPE_W-1:0]     dn_type [TABLE_DEPTH];
  logic [REM_W-1:0]      dn_rem  [TABLE_DEPTH];
  logic [TIME_W-1:0]     dn_dl   [TABLE_DEPTH];
  logic                  dn_ann  [TABLE_DEPTH];

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      service_time[0]    <= SERVICE0_RST;
      service_time[1]    <= SERVICE1_RST;
      service_time[2]    <= SERVICE2_RST;
      deadline_offset[0] <= DEADLINE0_RST;
      deadline_offset[1] <= DEADLINE1_RST;
      deadline_offset[2] <= DEADLINE2_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SERVICE0:  service_time[0]    <= cfg_data;
        REG_SERVICE1:  service_time[1]    <= cfg_data;
        REG_SERVICE2:  service_time[2]    <= cfg_data;
        REG_DEADLINE0: deadline_offset[0] <= cfg_data;
        REG_DEADLINE1: deadline_offset[1] <= cfg_data;
        REG_DEADLINE2: deadline_offset[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_kind <= in_data.kind;
      cur_type <= in_data.job_type;
    end
  end

  // Select per-type settings of the arriving job
  always_comb begin
    case (cur_type)
      JOB_TYPE0: begin
        sel_offset  = deadline_offset[0];
        sel_service = service_time[0];
      end
      JOB_TYPE1: begin
        sel_offset  = deadline_offset[1];
        sel_service = service_time[1];
      end
      JOB_TYPE2: begin
        sel_offset  = deadline_offset[2];
        sel_service = service_time[2];
      end
      default: begin
        sel_offset  = '0;
        sel_service = '0;
      end
    endcase
  end

  assign new_deadline = current_time + TIME_W'(sel_offset);
  assign head_type    = slot_type[0];
  assign head_done    = slot_remaining[0] <= REM_W'(1);
  assign recv_inc     = receive_count[head_type] + SERIAL_W'(1);
  assign fin_inc      = finish_count[head_type] + SERIAL_W'(1);

  // Table cells: insert after equal deadlines, shift down on removal
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= held) || (slot_deadline[i] > new_deadline);

    if (i == 0) begin : g_first
      assign prev_gt[i] = 1'b0;
      assign up_type[i] = cur_type;
      assign up_rem[i]  = sel_service;
      assign up_dl[i]   = new_deadline;
      assign up_ann[i]  = 1'b0;
    end else begin : g_mid
      assign prev_gt[i] = gt[i-1];
      assign up_type[i] = slot_type[i-1];
      assign up_rem[i]  = slot_remaining[i-1];
      assign up_dl[i]   = slot_deadline[i-1];
      assign up_ann[i]  = slot_announced[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign dn_type[i] = slot_type[i];
      assign dn_rem[i]  = slot_remaining[i];
      assign dn_dl[i]   = slot_deadline[i];
      assign dn_ann[i]  = slot_announced[i];
    end else begin : g_body
      assign dn_type[i] = slot_type[i+1];
      assign dn_rem[i]  = slot_remaining[i+1];
      assign dn_dl[i]   = slot_deadline[i+1];
      assign dn_ann[i]  = slot_announced[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && gt[i]) begin
        if (prev_gt[i]) begin
          slot_type[i]      <= up_type[i];
          slot_remaining[i] <= up_rem[i];
          slot_deadline[i]  <= up_dl[i];
          slot_announced[i] <= up_ann[i];
        end else begin
          slot_type[i]      <= cur_type;
          slot_remaining[i] <= sel_service;
          slot_deadline[i]  <= new_deadline;
          slot_announced[i] <= 1'b0;
        end
      end else if (cmd.load_fin) begin
        slot_type[i]      <= dn_type[i];
        slot_remaining[i] <= dn_rem[i];
        slot_deadline[i]  <= dn_dl[i];
        slot_announced[i] <= dn_ann[i];
      end else if (i == 0) begin
        if (cmd.load_recv) slot_announced[i] <= 1'b1;
        if (cmd.decrement) slot_remaining[i] <= slot_remaining[i] - REM_W'(1);
      end
    end
  end

  // Fill count and time base
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      current_time <= '0;
    end else begin
      if (cmd.insert)        held <= held + CNT_W'(1);
      else if (cmd.load_fin) held <= held - CNT_W'(1);
      if (cmd.tick) current_time <= current_time + TIME_W'(1);
    end
  end

  // Per-type serial counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        receive_count[t] <= '0;
        finish_count[t]  <= '0;
      end
    end else begin
      if (cmd.load_recv) receive_count[head_type] <= recv_inc;
      if (cmd.load_fin)  finish_count[head_type]  <= fin_inc;
    end
  end

  // Result register; a receive beat is last unless a finish follows
  always_ff @(posedge clk) begin
    if (cmd.load_recv) begin
      out_reg.event_res     <= EV_RECEIVE;
      out_reg.event_type    <= head_type;
      out_reg.serial_number <= recv_inc;
      out_reg.last          <= !head_done;
    end else if (cmd.load_fin) begin
      out_reg.event_res     <= EV_FINISH;
      out_reg.event_type    <= head_type;
      out_reg.serial_number <= fin_inc;
      out_reg.last          <= 1'b1;
    end else if (cmd.load_drop) begin
      out_reg.event_res     <= EV_DROP;
      out_reg.event_type    <= cur_type;
      out_reg.serial_number <= '0;
      out_reg.last          <= 1'b1;
    end
  end

  assign out_data = out_reg;

  // Status to the sequencer
  assign status.arrival   = cur_kind == KIND_ARRIVE;
  assign status.type_bad  = cur_type > JOB_TYPE2;
  assign status.full      = held == CNT_W'(TABLE_DEPTH);
  assign status.empty     = held == '0;
  assign status.announced = slot_announced[0];
  assign status.head_done = head_done;
  assign status.out_last  = out_reg.last;

endmodule

// ===== rtl/edf_job_scheduler.sv =====
// ----------------------------------------------------------------------------
// edf_job_scheduler
// Preemptive earliest-deadline-first scheduler over three job types.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. An arrival, or a tick that produces no
// result, is accepted and then handled in the evaluate state, in which the
// sorted table is updated by a row of compare-and-shift cells in parallel.
// A tick that produces results adds a send state for each result beat, held
// until the output side takes the beat, plus a state to build the finish beat
// when it follows a receive beat; a dropped arrival also adds a send state.
// A full table drops arrivals with a drop event; type three arrivals give no
// result. The job table needs no clearing after reset.
module edf_job_scheduler
  import edf_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  edf_cmd_t    cmd;
  edf_status_t status;

  // Sequencer
  edf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table, counters and result register
  edf_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
